// ----- sv/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants for the point charge field block
// Request and result layouts, register map, mode codes and sequencer states.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int MAX_CHARGES_DEF = 64;

    // register map, word index
    localparam logic [1:0] REG_GRID_W = 2'd0;
    localparam logic [1:0] REG_GRID_H = 2'd1;
    localparam logic [1:0] REG_COUL_K = 2'd2;

    localparam logic [12:0] GRID_W_RST = 13'd256;
    localparam logic [12:0] GRID_H_RST = 13'd256;
    localparam logic [31:0] COUL_K_RST = 32'd65536;

    // request modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // offsets saturate at +-2^34 LSB
    localparam logic signed [63:0] OFS_LIM = 64'sd17179869184;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] charge_x;
        logic signed [31:0] charge_y;
        logic signed [31:0] charge_value;
        logic [11:0]        pixel_x;
        logic [11:0]        pixel_y;
    } t_cmd;

    typedef struct packed {
        logic [63:0] intensity;
        logic        no_charges;
        logic        coincident;
    } t_res;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] q;
    } t_charge;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MAP, ST_DIVX, ST_DIVY, ST_RD, ST_OFS,
        ST_SQX, ST_SQY, ST_KQ, ST_NX, ST_DX, ST_NY, ST_DY,
        ST_FIN, ST_MX, ST_MY, ST_ROOT, ST_DONE
    } t_state;

endpackage

// ----- sv/pcf_store.sv -----
// ----------------------------------------------------------------------------
// pcf_store: charge memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pcf_store
    import pcf_pkg::*;
#(
    parameter int DEPTH = MAX_CHARGES_DEF,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_charge       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_charge       o_rdata
);

    t_charge r_mem [DEPTH];
    t_charge r_rdata;

    // write a loaded charge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read one entry per cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pcf_mul.sv -----
// ----------------------------------------------------------------------------
// pcf_mul: 64x64 unsigned multiplier
// Four 32x32 partial products, one per cycle, summed into a 128-bit product.
// ----------------------------------------------------------------------------
module pcf_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_prod
);

    logic         r_busy, r_done;
    logic [1:0]   r_step;
    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // select the halves of this step
    always_comb begin
        a_half = r_step[1] ? r_a[63:32] : r_a[31:0];
        b_half = r_step[0] ? r_b[63:32] : r_b[31:0];
        pp     = a_half * b_half;
        pp_sh  = {64'd0, pp} << ({5'd0, r_step[1]} + {5'd0, r_step[0]}) * 7'd32;
    end

    // sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // accumulate partial products
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- sv/pcf_div.sv -----
// ----------------------------------------------------------------------------
// pcf_div: restoring divider, 128-bit numerator
// One quotient bit per cycle; quotient saturates when it exceeds 64 bits.
// ----------------------------------------------------------------------------
module pcf_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [127:0]  i_num,
    input  logic [71:0]   i_den,
    output logic          o_done,
    output logic [63:0]   o_quo
);

    logic         r_busy, r_done, r_over;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [71:0]  r_den, r_rem;
    logic [63:0]  r_quo;
    logic [71:0]  rem_sh;
    logic         ge;

    // trial subtract
    always_comb begin
        rem_sh = {r_rem[70:0], r_num[127]};
        ge     = (rem_sh >= r_den);
    end

    // sequence the bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 7'd127);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // shift remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[126:0], 1'b0};
            r_rem <= ge ? (rem_sh - r_den) : rem_sh;
            if (!r_cnt[6]) begin
                r_over <= r_over | ge;
            end else begin
                r_quo <= {r_quo[62:0], ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_over ? '1 : r_quo;

endmodule

// ----- sv/pcf_sqrt.sv -----
// ----------------------------------------------------------------------------
// pcf_sqrt: digit-by-digit integer square root
// Two radicand bits per cycle across a 128-bit radicand.
// ----------------------------------------------------------------------------
module pcf_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [127:0]  i_rad,
    output logic          o_done,
    output logic [63:0]   o_root
);

    logic         r_busy, r_done;
    logic [5:0]   r_cnt;
    logic [127:0] r_rad;
    logic [66:0]  r_rem;
    logic [63:0]  r_root;
    logic [66:0]  rem_sh, trial;
    logic         ge;

    // trial subtract
    always_comb begin
        rem_sh = {r_rem[64:0], r_rad[127:126]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // sequence the digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // advance remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[125:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- sv/point_charge_field_magnitude_top.sv -----
// ----------------------------------------------------------------------------
// point_charge_field_magnitude_top: 2-D Coulomb field magnitude over charges
// Load, clear and query requests; one result per query, strobed for a cycle.
// ----------------------------------------------------------------------------
// Load and clear leave busy low; a query of an empty store answers next cycle.
// A query of charges holds busy until it ends and strobes its result in the
// cycle after; a charge on the pixel skips its multiply and divide steps.
// The divider, the slowest unit, runs twice per charge and once per axis.
// Synchronous active-low reset empties the store and restores register
// defaults; the store needs no clearing pass. Results cannot be stalled.
module point_charge_field_magnitude_top
    import pcf_pkg::*;
#(
    parameter int MAX_CHARGES = MAX_CHARGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int CW = $clog2(MAX_CHARGES + 1);

    // configuration
    logic [12:0] r_grid_w, r_grid_h;
    logic [31:0] r_coul_k;

    // store control and bounding box
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_bxl, r_bxh, r_byl, r_byh;

    // sequencer
    t_state        r_state, n_state;
    logic          r_wait, n_wait;
    logic [AW-1:0] r_idx;

    // query datapath
    logic [11:0]         r_px, r_py;
    logic signed [49:0]  r_numx, r_numy;
    logic signed [63:0]  r_xs, r_ys;
    logic [34:0]         r_ax, r_ay;
    logic                r_sx, r_sy, r_qn, r_coinc, r_ovf;
    logic [31:0]         r_qa;
    logic [71:0]         r_r2;
    logic [63:0]         r_kq, r_mx, r_my, r_res;
    logic [127:0]        r_np;
    logic signed [127:0] r_ex, r_ey;
    logic [128:0]        r_s;
    logic                r_out_valid;
    t_res                r_out;

    // units
    logic         mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
    logic         mul_fin, div_fin, sqrt_fin;
    logic [63:0]  mul_a, mul_b, div_quo, sqrt_root;
    logic [127:0] mul_prod, div_num;
    logic [71:0]  div_den;
    t_charge      rd_data, wr_data;
    logic         mem_we;

    // helpers
    logic               accepted, acc_load, acc_clear, acc_query, last, ofs_zero;
    logic [12:0]        nx_eff, ny_eff;
    logic [16:0]        den_x, den_y;
    logic signed [32:0] ext_x, ext_y;
    logic signed [16:0] fac_x, fac_y;
    logic signed [49:0] mag_x, mag_y;
    logic [50:0]        adj_x, adj_y;
    logic signed [63:0] dx_raw, dy_raw, dx_c, dy_c, adx, ady;
    logic signed [63:0] quo_s;
    logic [127:0]       abs_x, abs_y;
    logic [63:0]        fin_val;
    logic               cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= GRID_W_RST;
            r_grid_h <= GRID_H_RST;
            r_coul_k <= COUL_K_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_W: r_grid_w <= pwdata[12:0];
                REG_GRID_H: r_grid_h <= pwdata[12:0];
                REG_COUL_K: r_coul_k <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_W: prdata = {19'd0, r_grid_w};
            REG_GRID_H: prdata = {19'd0, r_grid_h};
            REG_COUL_K: prdata = r_coul_k;
            default:    prdata = '0;
        endcase
    end

    // ---------------- request decode ----------------
    assign busy      = (r_state != ST_IDLE);
    assign accepted  = start && !busy;
    assign acc_load  = accepted && (i_cmd.mode == MODE_LOAD);
    assign acc_clear = accepted && (i_cmd.mode == MODE_CLEAR);
    assign acc_query = accepted && (i_cmd.mode == MODE_QUERY);
    assign mem_we    = acc_load && (r_count < CW'(MAX_CHARGES));
    assign wr_data   = '{x: i_cmd.charge_x, y: i_cmd.charge_y, q: i_cmd.charge_value};
    assign last      = (CW'(r_idx) == r_count - CW'(1));

    // ---------------- charge memory and units ----------------
    pcf_store #(.DEPTH(MAX_CHARGES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    pcf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    pcf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quo(div_quo)
    );

    pcf_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_rad(r_s[127:0]), .o_done(sqrt_done), .o_root(sqrt_root)
    );

    assign mul_fin  = r_wait && mul_done;
    assign div_fin  = r_wait && div_done;
    assign sqrt_fin = r_wait && sqrt_done;

    // ---------------- pixel mapping terms ----------------
    always_comb begin
        nx_eff = (r_grid_w == '0) ? 13'd1 : r_grid_w;
        ny_eff = (r_grid_h == '0) ? 13'd1 : r_grid_h;
        den_x  = 17'(nx_eff) * 17'd10;
        den_y  = 17'(ny_eff) * 17'd10;
        ext_x  = {r_bxh[31], r_bxh} - {r_bxl[31], r_bxl};
        ext_y  = {r_byh[31], r_byh} - {r_byl[31], r_byl};
        fac_x  = $signed({1'b0, 16'(r_px) * 16'd12}) - $signed({4'd0, nx_eff});
        fac_y  = $signed({1'b0, 16'(r_py) * 16'd12}) - $signed({4'd0, ny_eff});
        // floor division of a negative numerator rounds its magnitude up
        mag_x  = r_numx[49] ? -r_numx : r_numx;
        mag_y  = r_numy[49] ? -r_numy : r_numy;
        adj_x  = {1'b0, mag_x} + (r_numx[49] ? 51'(den_x) - 51'd1 : 51'd0);
        adj_y  = {1'b0, mag_y} + (r_numy[49] ? 51'(den_y) - 51'd1 : 51'd0);
        quo_s  = $signed(div_quo);
    end

    // ---------------- offsets of the current charge ----------------
    always_comb begin
        dx_raw   = 64'(rd_data.x) - r_xs;
        dy_raw   = 64'(rd_data.y) - r_ys;
        dx_c     = (dx_raw > OFS_LIM) ? OFS_LIM : ((dx_raw < -OFS_LIM) ? -OFS_LIM : dx_raw);
        dy_c     = (dy_raw > OFS_LIM) ? OFS_LIM : ((dy_raw < -OFS_LIM) ? -OFS_LIM : dy_raw);
        adx      = dx_c[63] ? -dx_c : dx_c;
        ady      = dy_c[63] ? -dy_c : dy_c;
        ofs_zero = (dx_raw == '0) && (dy_raw == '0);
        abs_x    = r_ex[127] ? 128'(-r_ex) : 128'(r_ex);
        abs_y    = r_ey[127] ? 128'(-r_ey) : 128'(r_ey);
        fin_val  = (r_ovf || r_s[128]) ? '1 : r_res;
        if (fin_val == '0) begin
            fin_val = 64'd1;
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (acc_query && (r_count != '0)) n_state = ST_MAP;
            ST_MAP:  n_state = ST_DIVX;
            ST_DIVX: if (div_fin) n_state = ST_DIVY;
            ST_DIVY: if (div_fin) n_state = ST_RD;
            ST_RD:   n_state = ST_OFS;
            ST_OFS: begin
                if (ofs_zero) n_state = last ? ST_FIN : ST_RD;
                else          n_state = ST_SQX;
            end
            ST_SQX:  if (mul_fin) n_state = ST_SQY;
            ST_SQY:  if (mul_fin) n_state = ST_KQ;
            ST_KQ:   if (mul_fin) n_state = ST_NX;
            ST_NX:   if (mul_fin) n_state = ST_DX;
            ST_DX:   if (div_fin) n_state = ST_NY;
            ST_NY:   if (mul_fin) n_state = ST_DY;
            ST_DY:   if (div_fin) n_state = last ? ST_FIN : ST_RD;
            ST_FIN:  n_state = ST_MX;
            ST_MX: begin
                if (r_ovf)        n_state = ST_DONE;
                else if (mul_fin) n_state = ST_MY;
            end
            ST_MY:   if (mul_fin) n_state = ST_ROOT;
            ST_ROOT: if (r_s[128] || sqrt_fin) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- unit launch and operands ----------------
    always_comb begin
        mul_start  = !r_wait && ((r_state inside {ST_SQX, ST_SQY, ST_KQ, ST_NX, ST_NY,
                                                   ST_MY}) ||
                                 ((r_state == ST_MX) && !r_ovf));
        div_start  = !r_wait && (r_state inside {ST_DIVX, ST_DIVY, ST_DX, ST_DY});
        sqrt_start = !r_wait && (r_state == ST_ROOT) && !r_s[128];
        if (mul_start || div_start || sqrt_start) n_wait = 1'b1;
        else if (mul_fin || div_fin || sqrt_fin)  n_wait = 1'b0;
        else                                      n_wait = r_wait;

        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (r_state)
            ST_SQX:  begin mul_a = 64'(r_ax); mul_b = 64'(r_ax); end
            ST_SQY:  begin mul_a = 64'(r_ay); mul_b = 64'(r_ay); end
            ST_KQ:   begin mul_a = 64'(r_coul_k); mul_b = 64'(r_qa); end
            ST_NX:   begin mul_a = r_kq; mul_b = 64'(r_ax); end
            ST_NY:   begin mul_a = r_kq; mul_b = 64'(r_ay); end
            ST_MX:   begin mul_a = r_mx; mul_b = r_mx; end
            ST_MY:   begin mul_a = r_my; mul_b = r_my; end
            ST_DIVX: begin div_num = 128'(adj_x); div_den = 72'(den_x); end
            ST_DIVY: begin div_num = 128'(adj_y); div_den = 72'(den_y); end
            ST_DX, ST_DY: begin div_num = {r_np[111:0], 16'd0}; div_den = r_r2; end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= (acc_query && (r_count == '0)) || (r_state == ST_DONE);
            if (mem_we) begin
                r_count <= r_count + CW'(1);
            end else if (acc_clear) begin
                r_count <= '0;
            end
            // step to the next charge
            if (acc_query) begin
                r_idx <= '0;
            end else if (((r_state == ST_OFS) && ofs_zero) ||
                         ((r_state == ST_DY) && div_fin)) begin
                if (!last) r_idx <= r_idx + AW'(1);
            end
        end
    end

    // ---------------- bounding box ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bxl <= '0;
            r_bxh <= '0;
            r_byl <= '0;
            r_byh <= '0;
        end else if (acc_clear) begin
            r_bxl <= '0;
            r_bxh <= '0;
            r_byl <= '0;
            r_byh <= '0;
        end else if (mem_we) begin
            if (r_count == '0) begin
                r_bxl <= i_cmd.charge_x;
                r_bxh <= i_cmd.charge_x;
                r_byl <= i_cmd.charge_y;
                r_byh <= i_cmd.charge_y;
            end else begin
                if (i_cmd.charge_x < r_bxl) r_bxl <= i_cmd.charge_x;
                if (i_cmd.charge_x > r_bxh) r_bxh <= i_cmd.charge_x;
                if (i_cmd.charge_y < r_byl) r_byl <= i_cmd.charge_y;
                if (i_cmd.charge_y > r_byh) r_byh <= i_cmd.charge_y;
            end
        end
    end

    // ---------------- query datapath ----------------
    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_px    <= i_cmd.pixel_x;
            r_py    <= i_cmd.pixel_y;
            r_ex    <= '0;
            r_ey    <= '0;
            r_coinc <= 1'b0;
        end
        case (r_state)
            ST_MAP: begin
                r_numx <= ext_x * fac_x;
                r_numy <= ext_y * fac_y;
            end
            ST_DIVX: if (div_fin) r_xs <= 64'(r_bxl) + (r_numx[49] ? -quo_s : quo_s);
            ST_DIVY: if (div_fin) r_ys <= 64'(r_byl) + (r_numy[49] ? -quo_s : quo_s);
            ST_OFS: begin
                if (ofs_zero) r_coinc <= 1'b1;
                r_ax <= adx[34:0];
                r_ay <= ady[34:0];
                r_sx <= dx_c[63];
                r_sy <= dy_c[63];
                r_qn <= rd_data.q[31];
                r_qa <= rd_data.q[31] ? 32'(-rd_data.q) : 32'(rd_data.q);
            end
            ST_SQX: if (mul_fin) r_r2 <= mul_prod[71:0];
            ST_SQY: if (mul_fin) r_r2 <= r_r2 + mul_prod[71:0];
            ST_KQ:  if (mul_fin) r_kq <= mul_prod[63:0];
            ST_NX, ST_NY: if (mul_fin) r_np <= mul_prod;
            ST_DX: begin
                if (div_fin) begin
                    if (r_qn != r_sx) r_ex <= r_ex - $signed({64'd0, div_quo});
                    else              r_ex <= r_ex + $signed({64'd0, div_quo});
                end
            end
            ST_DY: begin
                if (div_fin) begin
                    if (r_qn != r_sy) r_ey <= r_ey - $signed({64'd0, div_quo});
                    else              r_ey <= r_ey + $signed({64'd0, div_quo});
                end
            end
            ST_FIN: begin
                r_mx  <= abs_x[63:0];
                r_my  <= abs_y[63:0];
                r_ovf <= (abs_x[127:64] != '0) || (abs_y[127:64] != '0);
            end
            ST_MX:   if (mul_fin) r_s <= {1'b0, mul_prod};
            ST_MY:   if (mul_fin) r_s <= r_s + {1'b0, mul_prod};
            ST_ROOT: if (sqrt_fin) r_res <= sqrt_root;
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (acc_query && (r_count == '0)) begin
            r_out <= '{intensity: 64'd1, no_charges: 1'b1, coincident: 1'b0};
        end else if (r_state == ST_DONE) begin
            r_out <= '{intensity: fin_val, no_charges: 1'b0, coincident: r_coinc};
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ----- sv/pcf_chk.sv -----
// ----------------------------------------------------------------------------
// pcf_chk: port-level checks for the point charge field block
// Watches requests, results and the configuration port over time.
// ----------------------------------------------------------------------------
module pcf_chk
    import pcf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_cmd i_cmd,
    input logic o_valid,
    input t_res o_res,
    input logic pready
);

    // intensity is floored at one LSB
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.intensity != '0))
        else $error("zero intensity");

    // an empty store answers with the fixed result
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.no_charges) |-> (o_res.intensity == 64'd1 && !o_res.coincident))
        else $error("bad empty-store result");

    // loads, clears and unused modes give no result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.mode != MODE_QUERY)) |=> !o_valid)
        else $error("result without a query");

    // a running query shows no result until it ends
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(busy) && busy) |-> !o_valid)
        else $error("result during a running query");

    // the configuration port never waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind point_charge_field_magnitude_top pcf_chk u_pcf_chk (.*);
